>>> rtl/ltp_pkg.sv
// Shared types and constants for the LRC timestamp line parser.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ltp_pkg;

    localparam int WIN_LEN = 10;

    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] BYTE_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] BYTE_COLON = 8'h3A;  // ':'
    localparam logic [7:0] BYTE_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] BYTE_NINE  = 8'h39;  // '9'

    localparam int MS_W   = 13;  // minutes * 60 + seconds, at most 6039
    localparam int CENT_W = 7;
    localparam int TIME_W = 20;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_TEXT  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // One queued word: the results that one input byte causes, in order
    // blank start, blank end, timed start, text byte, entry end.
    typedef struct packed {
        logic              blank;
        logic              start;
        logic              text;
        logic              fin;
        logic [MS_W-1:0]   min_sec;
        logic [CENT_W-1:0] cent;
        logic [7:0]        data;
    } cmd_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= BYTE_ZERO) && (b <= BYTE_NINE);
    endfunction

endpackage

>>> rtl/ltp_front.sv
// Front part: accepts text bytes, tracks the line window and line state,
// and turns each byte with results into one queued word. Depends on ltp_pkg.
module ltp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    text_byte,
    input  logic          end_of_text,
    input  logic          q_full,
    output logic          push,
    output ltp_pkg::cmd_t cmd
);
    import ltp_pkg::*;

    logic [7:0]  win_reg [WIN_LEN];
    logic [7:0]  win_next [WIN_LEN];
    logic [7:0]  win_shift [WIN_LEN];
    logic        matched_reg, matched_next;
    logic        open_reg, open_next;
    logic        seen_reg, seen_next;
    logic        accept;
    logic        is_lf;
    logic        is_tag;
    logic [6:0]  mins;
    logic [6:0]  secs;
    logic [6:0]  cent;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_lf    = (text_byte == BYTE_LF);

    always_comb
    begin
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            win_shift[i] = win_reg[i + 1];
        end
        win_shift[WIN_LEN - 1] = text_byte;
    end

    assign is_tag = (win_shift[0] == BYTE_OPEN) && is_digit(win_shift[1]) &&
                    is_digit(win_shift[2]) && (win_shift[3] == BYTE_COLON) &&
                    is_digit(win_shift[4]) && is_digit(win_shift[5]) &&
                    (win_shift[6] != BYTE_CR) && (win_shift[6] != BYTE_LF) &&
                    is_digit(win_shift[7]) && is_digit(win_shift[8]) &&
                    (win_shift[9] == BYTE_CLOSE);

    // A checked digit's value is its low nibble.
    assign mins = 7'({3'b000, win_shift[1][3:0]} * 7'd10) + {3'b000, win_shift[2][3:0]};
    assign secs = 7'({3'b000, win_shift[4][3:0]} * 7'd10) + {3'b000, win_shift[5][3:0]};
    assign cent = 7'({3'b000, win_shift[7][3:0]} * 7'd10) + {3'b000, win_shift[8][3:0]};

    always_comb
    begin
        win_next     = win_reg;
        matched_next = matched_reg;
        open_next    = open_reg;
        seen_next    = seen_reg;
        cmd          = '0;
        cmd.min_sec  = MS_W'(mins * MS_W'(60)) + MS_W'(secs);
        cmd.cent     = cent;
        cmd.data     = text_byte;

        if (is_lf)
        begin
            cmd.fin      = matched_reg;
            win_next     = '{default: '0};
            matched_next = 1'b0;
            open_next    = 1'b0;
        end
        else if (matched_reg)
        begin
            if (text_byte == BYTE_CR)
            begin
                open_next = 1'b0;
            end
            else if (open_reg)
            begin
                cmd.text = 1'b1;
            end
        end
        else
        begin
            win_next = win_shift;
            if (is_tag)
            begin
                cmd.blank    = !seen_reg;
                cmd.start    = 1'b1;
                seen_next    = 1'b1;
                matched_next = 1'b1;
                open_next    = 1'b1;
            end
        end

        // The last byte of a text also ends its line, then all state resets.
        if (end_of_text)
        begin
            if (!is_lf)
            begin
                cmd.fin = matched_next;
            end
            win_next     = '{default: '0};
            matched_next = 1'b0;
            open_next    = 1'b0;
            seen_next    = 1'b0;
        end
    end

    assign push = accept && (cmd.blank || cmd.start || cmd.text || cmd.fin);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= '{default: '0};
            matched_reg <= 1'b0;
            open_reg    <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else if (accept)
        begin
            win_reg     <= win_next;
            matched_reg <= matched_next;
            open_reg    <= open_next;
            seen_reg    <= seen_next;
        end
    end

endmodule

>>> rtl/ltp_queue.sv
// Short first-in first-out queue of words between front and back parts.
// Depends on ltp_pkg for the word type.
module ltp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ltp_pkg::cmd_t push_data,
    input  logic          pop,
    output ltp_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import ltp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/ltp_back.sv
// Back part: emits queued words' results via an output register, one
// per cycle while out_ready allows. Depends on ltp_pkg.
module ltp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ltp_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    result_kind,
    output logic [19:0]   time_cs,
    output logic [7:0]    out_byte,
    output logic          last_of_run
);
    import ltp_pkg::*;

    localparam int STEP_BLANK_START = 0;
    localparam int STEP_BLANK_END   = 1;
    localparam int STEP_START       = 2;
    localparam int STEP_TEXT        = 3;
    localparam int STEP_END         = 4;
    localparam int NSTEP            = 5;

    logic [NSTEP-1:0]  pend_reg, pend_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [7:0]        data_reg, data_next;

    logic              out_valid_reg;
    kind_t             kind_reg, kind_next;
    logic [TIME_W-1:0] otime_reg, otime_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              olast_reg, olast_next;

    logic              advance;
    logic [NSTEP-1:0]  pend_left;
    logic              finishing;

    assign advance = cur_valid_reg && (!out_valid_reg || out_ready);

    // Pick the first pending step and form its result.
    always_comb
    begin
        pend_left  = pend_reg;
        kind_next  = KIND_END;
        otime_next = '0;
        obyte_next = '0;
        if (pend_reg[STEP_BLANK_START])
        begin
            pend_left[STEP_BLANK_START] = 1'b0;
            kind_next = KIND_START;
        end
        else if (pend_reg[STEP_BLANK_END])
        begin
            pend_left[STEP_BLANK_END] = 1'b0;
        end
        else if (pend_reg[STEP_START])
        begin
            pend_left[STEP_START] = 1'b0;
            kind_next  = KIND_START;
            otime_next = time_reg;
        end
        else if (pend_reg[STEP_TEXT])
        begin
            pend_left[STEP_TEXT] = 1'b0;
            kind_next  = KIND_TEXT;
            obyte_next = data_reg;
        end
        else
        begin
            pend_left[STEP_END] = 1'b0;
        end
    end

    assign finishing  = (pend_left == '0);
    assign olast_next = finishing;
    assign pop        = !q_empty && (!cur_valid_reg || (advance && finishing));

    always_comb
    begin
        pend_next      = pend_reg;
        cur_valid_next = cur_valid_reg;
        time_next      = time_reg;
        data_next      = data_reg;
        if (advance)
        begin
            pend_next = pend_left;
            if (finishing)
            begin
                cur_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            cur_valid_next = 1'b1;
            pend_next      = {head.fin, head.text, head.start, head.blank, head.blank};
            time_next      = TIME_W'(head.min_sec * TIME_W'(100)) + TIME_W'(head.cent);
            data_next      = head.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pend_reg      <= pend_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        data_reg <= data_next;
        if (advance)
        begin
            kind_reg  <= kind_next;
            otime_reg <= otime_next;
            obyte_reg <= obyte_next;
            olast_reg <= olast_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign time_cs     = otime_reg;
    assign out_byte    = obyte_reg;
    assign last_of_run = olast_reg;

endmodule

>>> rtl/lrc_timestamp_line_parser.sv
// LRC timestamp line parser, top level: front part, word queue, back part.
// A byte's first result passes queue, current-word and output registers. One
// byte per cycle while the queue has room, one result per cycle while out_ready
// allows; a byte's k results (k at most 4) hold the back part, setting the rate.
// Reset (rst_n, asynchronous, active low) clears the window, line state and queue.
module lrc_timestamp_line_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [19:0] time_cs,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);
    import ltp_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    ltp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    ltp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head_cmd),
        .empty     (q_empty),
        .full      (q_full)
    );

    ltp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .time_cs     (time_cs),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    // Only entry starts carry a time, and only text words carry a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind != KIND_START) |-> time_cs == '0)
        else $error("time set on a word that is not an entry start");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind != KIND_TEXT) |-> out_byte == '0)
        else $error("byte set on a word that is not entry text");

    // A full queue must hold off the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ready)
        else $error("input taken while the queue is full");

endmodule
